### hw/rtl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg
// Types and codes shared by the membership table controller and datapath.
// ----------------------------------------------------------------------------
package hmt_pkg;

    localparam int ID_W   = 31;
    localparam int PORT_W = 16;
    localparam int HB_W   = 31;
    localparam int TIME_W = 32;
    localparam int TO_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 31;

    // input kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_JOIN  = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;
    localparam logic [1:0] KIND_GOSS  = 2'd3;

    // result events
    localparam logic [1:0] EV_LIST   = 2'd0;
    localparam logic [1:0] EV_ADD    = 2'd1;
    localparam logic [1:0] EV_REMOVE = 2'd2;
    localparam logic [1:0] EV_DROP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_TO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IN  = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   hb;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [1:0]        ev;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   hb;
        logic              failed;
        logic              is_self;
        logic              reply;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_INSERT = 3'd2,
        OP_AGE    = 3'd3,
        OP_SELF   = 3'd4,
        OP_LIST   = 3'd5,
        OP_FLUSH  = 3'd6
    } t_op;

    typedef struct packed {
        logic latch;
        logic rd_en;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic fire;
        logic hit;
        logic in_group;
        logic pend_valid;
    } t_sts;

endpackage

### hw/rtl/hmt_ctrl.sv
// ----------------------------------------------------------------------------
// hmt_ctrl
// Sequencer: walks the slots for lookup, ageing and list output.
// ----------------------------------------------------------------------------
module hmt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  hmt_pkg::t_sts      i_sts,
    output hmt_pkg::t_cmd      o_cmd,
    output logic [IDX_W-1:0]   o_idx
);
    import hmt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_EX    = 6'b000100,
        S_INS   = 6'b001000,
        S_SELF  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        P_LOOK = 2'd0,
        P_AGE  = 2'd1,
        P_LIST = 2'd2
    } t_phase;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_kind, n_kind;
    logic             w_end;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_idx      = r_idx;
    assign w_end      = (r_idx == LAST_IDX);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_kind  = r_kind;
        o_cmd   = '{latch: 1'b0, rd_en: 1'b0, op: OP_NONE};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_kind = i_kind;
                    n_idx  = '0;
                    if (i_kind == KIND_TICK) begin
                        n_phase = P_AGE;
                        n_state = i_sts.in_group ? S_RD : S_IDLE;
                    end else begin
                        n_phase = P_LOOK;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_EX;
            end
            S_EX: begin
                unique case (r_phase)
                    P_LOOK:  o_cmd.op = OP_LOOKUP;
                    P_AGE:   o_cmd.op = OP_AGE;
                    default: o_cmd.op = OP_LIST;
                endcase
                if (i_sts.fire) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_RD;
                    unique case (r_phase)
                        P_LOOK: begin
                            if (i_sts.hit) begin
                                n_state = (r_kind == KIND_JOIN) ? S_SELF : S_FLUSH;
                            end else if (w_end) begin
                                n_state = S_INS;
                            end
                        end
                        P_AGE: begin
                            if (w_end) n_state = S_SELF;
                        end
                        default: begin
                            if (w_end) n_state = S_FLUSH;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_cmd.op = OP_INSERT;
                if (i_sts.fire) n_state = (r_kind == KIND_JOIN) ? S_SELF : S_FLUSH;
            end
            S_SELF: begin
                o_cmd.op = OP_SELF;
                if (i_sts.fire) begin
                    n_phase = P_LIST;
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                o_cmd.op = OP_FLUSH;
                if (i_sts.fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_LOOK;
            r_idx   <= '0;
            r_kind  <= KIND_TICK;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_kind  <= n_kind;
        end
    end

endmodule

### hw/rtl/hmt_dp.sv
// ----------------------------------------------------------------------------
// hmt_dp
// Slot memory, valid and failed marks, config registers and result staging.
// ----------------------------------------------------------------------------
module hmt_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hmt_pkg::t_cmd                 i_cmd,
    input  logic [IDX_W-1:0]              i_idx,
    output hmt_pkg::t_sts                 o_sts,
    input  logic [1:0]                    i_kind,
    input  logic [hmt_pkg::ID_W-1:0]      i_member_id,
    input  logic [hmt_pkg::PORT_W-1:0]    i_member_port,
    input  logic [hmt_pkg::HB_W-1:0]      i_member_heartbeat,
    input  logic [hmt_pkg::TIME_W-1:0]    i_current_time,
    input  logic                          i_cfg_we,
    input  logic [hmt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hmt_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output hmt_pkg::t_result              o_out
);
    import hmt_pkg::*;

    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid, r_failed, n_failed;
    logic [IDX_W-1:0]    r_free, n_free;
    logic                r_free_ok, n_free_ok;
    logic [1:0]          r_kind;
    logic [ID_W-1:0]     r_id;
    logic [PORT_W-1:0]   r_port;
    logic [HB_W-1:0]     r_hb, r_own_hb, n_own_hb;
    logic [TIME_W-1:0]   r_now;
    logic [TO_W-1:0]     r_fail_to, r_rm_to;
    logic [ID_W-1:0]     r_own_id;
    logic [PORT_W-1:0]   r_own_port;
    logic                r_in_group, n_in_group;
    t_result             r_pend, n_pend, r_out, n_out, w_new;
    logic                r_pend_valid, n_pend_valid, r_out_valid, n_out_valid;
    logic                w_emit, w_emit_ok, w_fire, w_out_free, w_hit, w_match;
    logic                w_rm, w_mk, w_own;
    logic                w_wr;
    logic [IDX_W-1:0]    w_wr_addr;
    t_entry              w_wr_data;
    logic [TIME_W-1:0]   w_age;
    logic [TO_W:0]       w_limit;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit_ok  = !r_pend_valid || w_out_free;
    assign w_match    = (r_rd.id == r_id) && (r_rd.port == r_port);
    assign w_hit      = r_valid[i_idx] && w_match;
    assign w_age      = r_now - r_rd.stamp;
    assign w_limit    = {1'b0, r_fail_to} + {1'b0, r_rm_to};
    assign w_rm = r_valid[i_idx] && r_failed[i_idx]
                  && (w_age >= {{(TIME_W-TO_W-1){1'b0}}, w_limit});
    assign w_mk = r_valid[i_idx] && !r_failed[i_idx]
                  && (w_age >= {{(TIME_W-TO_W){1'b0}}, r_fail_to});
    assign w_own = (r_id == r_own_id) && (r_port == r_own_port);

    always_comb begin
        w_emit = 1'b0;
        w_new  = '{ev: EV_LIST, id: r_id, port: r_port, hb: r_hb, failed: 1'b0,
                   is_self: 1'b0, reply: (r_kind == KIND_JOIN), last: 1'b0};
        unique case (i_cmd.op)
            OP_INSERT: begin
                w_emit   = !w_own;
                w_new.ev = r_free_ok ? EV_ADD : EV_DROP;
                w_new.reply = 1'b0;
            end
            OP_AGE: begin
                w_emit = w_rm;
                w_new  = '{ev: EV_REMOVE, id: r_rd.id, port: r_rd.port, hb: r_rd.hb,
                           failed: 1'b0, is_self: 1'b0, reply: 1'b0, last: 1'b0};
            end
            OP_SELF: begin
                w_emit = 1'b1;
                w_new.id = r_own_id;
                w_new.port = r_own_port;
                w_new.hb = r_own_hb;
                w_new.is_self = 1'b1;
            end
            OP_LIST: begin
                w_emit = r_valid[i_idx];
                w_new.id = r_rd.id;
                w_new.port = r_rd.port;
                w_new.hb = r_rd.hb;
                w_new.failed = r_failed[i_idx];
            end
            OP_FLUSH: w_emit = r_pend_valid;
            default: w_emit = 1'b0;
        endcase
    end

    assign w_fire = (i_cmd.op != OP_NONE) && (!w_emit || w_emit_ok);

    always_comb begin
        n_valid      = r_valid;
        n_failed     = r_failed;
        n_free       = r_free;
        n_free_ok    = r_free_ok;
        n_own_hb     = r_own_hb;
        n_in_group   = r_in_group;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_wr         = 1'b0;
        w_wr_addr    = i_idx;
        w_wr_data    = '{id: r_rd.id, port: r_rd.port, hb: r_hb, stamp: r_now};
        if (i_cmd.latch) begin
            n_free_ok = 1'b0;
            if (i_kind == KIND_REPLY) n_in_group = 1'b1;
            if (i_kind == KIND_TICK && r_in_group) n_own_hb = r_own_hb + 1'b1;
        end
        if (w_fire) begin
            unique case (i_cmd.op)
                OP_LOOKUP: begin
                    if (w_hit) begin
                        if (r_rd.hb < r_hb) begin
                            w_wr = 1'b1;
                            n_failed[i_idx] = 1'b0;
                        end
                    end else if (!r_valid[i_idx] && !r_free_ok) begin
                        n_free    = i_idx;
                        n_free_ok = 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (!w_own && r_free_ok) begin
                        w_wr      = 1'b1;
                        w_wr_addr = r_free;
                        w_wr_data = '{id: r_id, port: r_port, hb: r_hb, stamp: r_now};
                        n_valid[r_free]  = 1'b1;
                        n_failed[r_free] = 1'b0;
                    end
                end
                OP_AGE: begin
                    if (w_rm) begin
                        n_valid[i_idx]  = 1'b0;
                        n_failed[i_idx] = 1'b0;
                    end else if (w_mk) begin
                        n_failed[i_idx] = 1'b1;
                    end
                end
                default: ;
            endcase
            if (w_emit) begin
                if (r_pend_valid) begin
                    n_out       = r_pend;
                    n_out.last  = (i_cmd.op == OP_FLUSH);
                    n_out_valid = 1'b1;
                end
                n_pend       = w_new;
                n_pend_valid = (i_cmd.op != OP_FLUSH);
            end
        end
        if (i_cfg_we && i_cfg_index == CFG_START_IN) n_in_group = i_cfg_data[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_wr_addr] <= w_wr_data;
        if (i_cmd.rd_en) r_rd <= r_mem[i_idx];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_free <= n_free;
        r_pend <= n_pend;
        r_out  <= n_out;
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_id   <= i_member_id;
            r_port <= i_member_port;
            r_hb   <= i_member_heartbeat;
            r_now  <= i_current_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_failed     <= '0;
            r_free_ok    <= 1'b0;
            r_own_hb     <= '0;
            r_in_group   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fail_to    <= 16'd5;
            r_rm_to      <= 16'd20;
            r_own_id     <= 31'd1;
            r_own_port   <= '0;
        end else begin
            r_valid      <= n_valid;
            r_failed     <= n_failed;
            r_free_ok    <= n_free_ok;
            r_own_hb     <= n_own_hb;
            r_in_group   <= n_in_group;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FAIL_TO:   r_fail_to  <= i_cfg_data[TO_W-1:0];
                    CFG_REMOVE_TO: r_rm_to    <= i_cfg_data[TO_W-1:0];
                    CFG_OWN_ID:    r_own_id   <= i_cfg_data[ID_W-1:0];
                    CFG_OWN_PORT:  r_own_port <= i_cfg_data[PORT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_sts = '{fire: w_fire, hit: w_hit, in_group: r_in_group,
                     pend_valid: r_pend_valid};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hw/rtl/heartbeat_membership_table.sv
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Membership table of a heartbeat failure detector with a slot sequencer.
// ----------------------------------------------------------------------------
// each slot is read in S_RD and handled in S_EX, one slot after another
// join/gossip: lookup scan, insert on a miss; gossip then flushes the staged word
// tick in the group: age scan; join and such a tick then give self, list, flush
// one item at a time; output stalls hold the sequencer once both result registers fill
// reset: slots invalid, own heartbeat zero, config registers at their defaults
module heartbeat_membership_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [hmt_pkg::ID_W-1:0]      i_member_id,
    input  logic [hmt_pkg::PORT_W-1:0]    i_member_port,
    input  logic [hmt_pkg::HB_W-1:0]      i_member_heartbeat,
    input  logic [hmt_pkg::TIME_W-1:0]    i_current_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_event_res,
    output logic [hmt_pkg::ID_W-1:0]      o_entry_id,
    output logic [hmt_pkg::PORT_W-1:0]    o_entry_port,
    output logic [hmt_pkg::HB_W-1:0]      o_entry_heartbeat,
    output logic                          o_entry_failed,
    output logic                          o_entry_is_self,
    output logic                          o_reply_to_joiner,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hmt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hmt_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import hmt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    t_cmd             w_cmd;
    t_sts             w_sts;
    t_result          w_out;
    logic [IDX_W-1:0] w_idx;

    assign o_cfg_ready = 1'b1;

    hmt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    hmt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_idx              (w_idx),
        .o_sts              (w_sts),
        .i_kind             (i_kind),
        .i_member_id        (i_member_id),
        .i_member_port      (i_member_port),
        .i_member_heartbeat (i_member_heartbeat),
        .i_current_time     (i_current_time),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out              (w_out)
    );

    assign o_event_res       = w_out.ev;
    assign o_entry_id        = w_out.id;
    assign o_entry_port      = w_out.port;
    assign o_entry_heartbeat = w_out.hb;
    assign o_entry_failed    = w_out.failed;
    assign o_entry_is_self   = w_out.is_self;
    assign o_reply_to_joiner = w_out.reply;
    assign o_last            = w_out.last;

    // busy straight after an accepted word, unless it was a tick outside the group
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind != KIND_TICK || w_sts.in_group))
        |=> o_in_stall)
        else $error("input accepted while idle did not start work");

    // no staged result may be left behind once idle
    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_sts.pend_valid)
        else $error("staged result left when idle");

    // only list words carry the own-entry or failed marks
    a_self_is_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_entry_is_self || o_entry_failed)) |-> (o_event_res == EV_LIST))
        else $error("mark on a non-list word");

endmodule
